[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared types and constants for the controller and datapath of the
// linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Fixed port widths.
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Request type codes.
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PRIME,
        S_CHECK,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_write;
        logic load;
        logic hash_step;
        logic prime;
        logic check;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic chk_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/lpht_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// State machine that sequences the clearing pass, the hash computation,
// the probe loop and the result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.hash_last) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.chk_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/lpht_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Slot memory, modulo unit for the home slot, probe address logic and
// the output register.
// ----------------------------------------------------------------------------
module lpht_dpath
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_BITS   = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_req_type,
    input  wire logic [KEY_W-1:0]  i_key,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [SLOT_W-1:0]      o_slot
);

    // Derived widths.
    localparam int AW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int SH  = KW + AW;
    localparam int MW  = SH + KW;
    localparam int RW  = (KW > AW) ? KW : AW;
    localparam int XW  = (AW > SLOT_W) ? AW : SLOT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
    localparam logic [AW:0]   MODULUS   = (AW + 1)'(TABLE_SIZE);
    // Rounded-up reciprocal of the table size, exact for every key of KW bits.
    localparam logic [KW:0]   RECIP     =
        (KW + 1)'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

    // Slot memory: a used flag above the stored key.
    logic [KW:0]       r_mem [TABLE_SIZE];
    logic [KW:0]       r_rd_data;

    logic [KW-1:0]     r_key;
    logic [MW-1:0]     r_prod;
    logic              r_dig;
    logic [AW-1:0]     r_rem;
    logic              r_is_search;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_chk;
    logic [AW-1:0]     r_count;
    t_status           r_res_status;
    logic [AW-1:0]     r_res_slot;
    logic              r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0] r_slot;

    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [KW:0]       mem_wdata;
    logic [KW-1:0]     quot;
    logic [KW+AW:0]    quot_mul;
    logic [RW-1:0]     rem_full;
    logic              slot_used;
    logic              key_hit;
    logic              probe_last;
    logic              chk_done;
    t_status           chk_status;
    logic [XW-1:0]     slot_ext;

    function automatic logic [AW-1:0] addr_next(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == LAST_SLOT) ? '0 : a + AW'(1);
        return r;
    endfunction

    // Home slot: the registered product with the reciprocal gives the quotient,
    // and the remainder follows from one multiply and subtract.
    assign quot     = r_prod[MW-1:SH];
    assign quot_mul = (KW + AW + 1)'(quot) * (KW + AW + 1)'(MODULUS);
    assign rem_full = RW'(r_key) - quot_mul[RW-1:0];

    // Probe evaluation of the slot whose contents sit in the read register.
    assign slot_used  = r_rd_data[KW];
    assign key_hit    = slot_used && (r_rd_data[KW-1:0] == r_key);
    assign probe_last = (r_count == LAST_SLOT);
    assign chk_done   = !slot_used || (r_is_search && key_hit) || probe_last;

    always_comb begin
        if ((!slot_used && !r_is_search) || (r_is_search && key_hit)) begin
            chk_status = ST_OK;
        end else if (r_is_search) begin
            chk_status = ST_NOT_FOUND;
        end else begin
            chk_status = ST_FULL;
        end
    end

    // Memory port control.
    assign rd_addr   = i_cmd.prime ? r_rem : r_addr;
    assign mem_we    = i_cmd.clr_write || (i_cmd.check && !r_is_search && !slot_used);
    assign mem_waddr = i_cmd.clr_write ? r_addr : r_chk;
    assign mem_wdata = i_cmd.clr_write ? '0 : {1'b1, r_key};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control registers: probe address and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_addr <= addr_next(r_addr);
            end else if (i_cmd.prime) begin
                r_addr <= addr_next(r_rem);
            end else if (i_cmd.check && !chk_done) begin
                r_addr <= addr_next(r_addr);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, hash and probe payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= i_key[KW-1:0];
            r_dig       <= 1'b0;
            r_rem       <= '0;
            r_is_search <= (i_req_type == REQ_SEARCH);
        end
        if (i_cmd.hash_step) begin
            if (!r_dig) begin
                r_prod <= MW'(r_key) * MW'(RECIP);
            end else begin
                r_rem <= rem_full[AW-1:0];
            end
            r_dig <= !r_dig;
        end
        if (i_cmd.prime) begin
            r_chk   <= r_rem;
            r_count <= '0;
        end
        if (i_cmd.check) begin
            if (chk_done) begin
                r_res_status <= chk_status;
                r_res_slot   <= (chk_status == ST_OK) ? r_chk : '0;
            end else begin
                r_chk   <= r_addr;
                r_count <= r_count + AW'(1);
            end
        end
    end

    // Output register.
    assign slot_ext = XW'(r_res_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= r_res_status;
            r_slot   <= slot_ext[SLOT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_sts.clr_last  = (r_addr == LAST_SLOT);
    assign o_sts.hash_last = r_dig;
    assign o_sts.chk_done  = chk_done;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // A failed request never reports a slot.
    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_slot == '0))
        else $error("nonzero slot with failing status");

    // The home slot produced by the modulo unit lies inside the table.
    a_home_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prime |-> (r_rem <= LAST_SLOT))
        else $error("home slot outside the table");

    // The read-ahead address is always one slot beyond the checked slot.
    a_read_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |-> (r_addr == addr_next(r_chk)))
        else $error("read-ahead address out of step with checked slot");

    // A probe that keeps going advances the probe count by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.check && !chk_done) |=> (r_count == $past(r_count) + AW'(1)))
        else $error("probe count did not advance");

endmodule
`default_nettype wire

[rtl/linear_probe_hash_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: accept, then hash (reciprocal multiply, then remainder), a memory prime,
// one check per probed slot (1 to TABLE_SIZE slots), and an output load.
// Requests: a new one is taken only after the last result loads into the output register, which
// can wait behind a stalled output; the one-read-per-cycle slot memory sets the probe rate.
// Reset: a clearing pass empties every slot; input stalls until done.
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing hash table with linear probing: insert or search one
// key per transaction, one result transaction per request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_BITS   = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_req_type,
    input  wire logic [KEY_W-1:0]    i_key,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_W-1:0]        o_slot
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Slot memory, hashing and result path.
    lpht_dpath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BITS   (KEY_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

endmodule
`default_nettype wire
